// ===== rtl/sfd_pkg.sv =====
// sfd_pkg: shared types and constants for the sentinel frame deframer
// no dependencies; imported by all rtl modules

package sfd_pkg;

	// default width of the binary frame length counter
	localparam int unsigned LENGTH_BITS_DEF = 31;

	// byte codes seen on the framed stream
	localparam logic [7:0] BYTE_END       = 8'hFF;
	localparam logic [7:0] TYPE_TEXT_GOOD = 8'h00;
	localparam logic [7:0] BYTE_MORE_BIT  = 8'h80;
	localparam logic [7:0] BYTE_LOW_MASK  = 8'h7F;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       message_end;
		logic       message_error;
		logic       link_closed;
	} out_item_t;

	// contents of the input register handed to the frame logic
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

endpackage

// ===== rtl/sfd_stream_if.sv =====
// sfd_stream_if: valid/ready channel carrying one payload item per transfer
// payload type is set per instance; used with types from sfd_pkg

interface sfd_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sfd_in_stage.sv =====
// sfd_in_stage: input register of the deframer, takes one byte per transfer
// depends on sfd_pkg

module sfd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sfd_pkg::in_item_t in_item,
	input  logic              advance,
	output sfd_pkg::stage_t   stage_s1
);
	import sfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	// register is free when empty or when its byte moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_item.rx_byte;
		end
	end

	assign stage_s1.valid   = valid_s1;
	assign stage_s1.rx_byte = byte_s1;

endmodule

// ===== rtl/sfd_frame_fsm.sv =====
// sfd_frame_fsm: frame phase tracking, length counting and result register
// depends on sfd_pkg

module sfd_frame_fsm #(
	parameter int unsigned LENGTH_BITS = sfd_pkg::LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfd_pkg::stage_t    stage_s1,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_ready,
	output sfd_pkg::out_item_t out_item
);
	import sfd_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_LEN    = 3'd1,
		PH_SKIP   = 3'd2,
		PH_TEXT   = 3'd3,
		PH_CLOSED = 3'd4
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic                   good_q, good_d;
	logic                   out_valid_q;
	out_item_t              out_q, res;
	logic                   fire;
	logic [LENGTH_BITS-1:0] len_shift;
	logic [LENGTH_BITS-1:0] len_dec;
	logic                   len_ovf;
	logic [7:0]             b;

	assign advance = !out_valid_q || out_ready;
	assign fire    = stage_s1.valid && advance;
	assign b       = stage_s1.rx_byte;

	// overflow when any of the top seven bits is set before the shift
	assign len_ovf   = |len_q[LENGTH_BITS-1 -: 7];
	assign len_shift = {len_q[LENGTH_BITS-8:0], b[6:0]};
	assign len_dec   = len_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		good_d  = good_q;
		res     = '0;
		unique case (phase_q)
			PH_CLOSED: begin
				res.link_closed = 1'b1;
			end
			PH_LEN: begin
				if (len_ovf) begin
					res.message_error = 1'b1;
					res.link_closed   = 1'b1;
					phase_d           = PH_CLOSED;
				end else begin
					len_d = len_shift;
					if ((b & BYTE_MORE_BIT) == '0) begin
						if (len_shift == '0) begin
							res.message_error = 1'b1;
							phase_d           = PH_TYPE;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				len_d = len_dec;
				if (len_dec == '0) begin
					res.message_error = 1'b1;
					phase_d           = PH_TYPE;
				end
			end
			PH_TEXT: begin
				if (b == BYTE_END) begin
					res.message_end   = good_q;
					res.message_error = !good_q;
					phase_d           = PH_TYPE;
				end else if (good_q) begin
					res.data_valid = 1'b1;
					res.data_byte  = b;
				end
			end
			default: begin
				if ((b & BYTE_MORE_BIT) != '0) begin
					len_d   = '0;
					phase_d = PH_LEN;
				end else begin
					good_d  = (b == TYPE_TEXT_GOOD);
					phase_d = PH_TEXT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			len_q       <= '0;
			good_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= stage_s1.valid;
			end
			if (fire) begin
				phase_q <= phase_d;
				len_q   <= len_d;
				good_q  <= good_d;
				out_q   <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_end_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.message_end && out_q.message_error))
		else $error("message_end and message_error in one result");

	a_data_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.data_valid) |->
		!(out_q.message_end || out_q.message_error || out_q.link_closed))
		else $error("payload byte flagged with frame status");

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLOSED) |=> (phase_q == PH_CLOSED))
		else $error("left closed phase without reset");

	a_closed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.link_closed) |-> (phase_q == PH_CLOSED))
		else $error("link_closed shown while not closed");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (len_q != '0))
		else $error("skip phase with zero bytes left");
`endif

endmodule

// ===== rtl/sentinel_frame_deframer_top.sv =====
// sentinel_frame_deframer_top: byte-serial deframer for sentinel framed streams
// depends on sfd_pkg, sfd_stream_if, sfd_in_stage and sfd_frame_fsm

// Deframes a received byte stream from reset on. Each byte
// arriving on rx gives exactly one result on tx. A type byte with bit 7 set
// opens a binary frame: base-128 length bytes follow (bit 7 set means more),
// the payload is skipped and message_error is flagged on its last byte, or on
// the final length byte when the length is zero. If the length would exceed
// LENGTH_BITS bits, that byte flags message_error and link_closed and the
// block closes: every later byte yields link_closed only, until reset. Any
// other type byte opens a text frame ending at 0xFF; type 0x00 passes its
// payload bytes out with data_valid and ends with message_end, any other type
// ends with message_error. Type bytes yield an all-zero result.
// Rate: one byte per clock cycle sustained while tx takes every result. A
// byte passes through the input register, then the result register, on its
// way to tx. The phase and length registers update as each byte moves into
// the result register. While a result waits on tx the input register still
// takes one byte if it is empty, then rx stalls until tx takes the result.

module sentinel_frame_deframer_top #(
	parameter int unsigned LENGTH_BITS = sfd_pkg::LENGTH_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sfd_stream_if.sink   rx,
	sfd_stream_if.source tx
);
	import sfd_pkg::*;

	// input register contents and the stall signal from the result side
	stage_t    stage_s1;
	logic      advance;
	in_item_t  rx_item;
	out_item_t tx_item;

	assign rx_item = rx.payload;

	// input register: byte held here while the frame logic works on it
	sfd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_item  (rx_item),
		.advance  (advance),
		.stage_s1 (stage_s1)
	);

	// frame phase, length counter and result register
	sfd_frame_fsm #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_frame_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage_s1  (stage_s1),
		.advance   (advance),
		.out_valid (tx.valid),
		.out_ready (tx.ready),
		.out_item  (tx_item)
	);

	assign tx.payload = tx_item;

endmodule
